/* rtl/sbs_pkg.sv */
`timescale 1ns / 1ps

package sbs_pkg;

  localparam int ENTRIES      = 32;
  localparam int MAX_SEARCHES = 32;
  localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int USED_W       = $clog2(ENTRIES + 1);
  localparam int SRCH_W       = $clog2(MAX_SEARCHES + 1);
  localparam int ID_W         = 32;
  localparam int TIME_W       = 32;
  localparam int GUARD_W      = 16;
  localparam int COUNT_W      = 9;
  localparam int KIND_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int FIFO_DEPTH   = 2;
  localparam int FIFO_PTR_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [GUARD_W-1:0] GUARD_RST    = GUARD_W'(100);
  localparam logic [COUNT_W-1:0] CAP_RST      = COUNT_W'(1 << 8);
  localparam logic [COUNT_W-1:0] FALLBACK_RST = COUNT_W'((1 << 7) + 1);
  localparam logic [COUNT_W-1:0] BOOST_RST    = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] INITIAL_RST  = COUNT_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER   = 3'd0,
    KIND_UNREGISTER = 3'd1,
    KIND_ANSWER     = 3'd2,
    KIND_NEW_SERVER = 3'd3,
    KIND_TICK       = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    OP_REG    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_BOOST  = 3'd2,
    OP_TICK   = 3'd3,
    OP_NOP    = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED  = 3'd0,
    CFG_GUARD    = 3'd1,
    CFG_CAP      = 3'd2,
    CFG_FALLBACK = 3'd3,
    CFG_BOOST    = 3'd4,
    CFG_INITIAL  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    op_e                op;
    logic [ID_W-1:0]    id;
    logic               penalize;
    logic [TIME_W-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic               enabled;
    logic [GUARD_W-1:0] guard_ms;
    logic [COUNT_W-1:0] count_cap;
    logic [COUNT_W-1:0] fallback_count;
    logic [COUNT_W-1:0] boost_count;
    logic [COUNT_W-1:0] initial_count;
  } cfg_t;

  function automatic logic pow2(input logic [COUNT_W-1:0] c);
    return (c != '0) && ((c & (c - COUNT_W'(1))) == '0);
  endfunction

endpackage

/* rtl/sbs_if.sv */
`timescale 1ns / 1ps

interface sbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [sbs_pkg::KIND_W-1:0]  kind;
  logic [sbs_pkg::ID_W-1:0]    channel_id;
  logic                        penalize;
  logic [sbs_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, kind, channel_id, penalize, now_ms, input ready);
  modport sink (input valid, kind, channel_id, penalize, now_ms, output ready);
endinterface

interface sbs_out_if;
  logic                          valid;
  logic                          ready;
  logic [sbs_pkg::ID_W-1:0]      search_id;
  logic                          is_search;
  logic [sbs_pkg::STATUS_W-1:0]  status;
  logic                          last;

  modport source (output valid, search_id, is_search, status, last, input ready);
  modport sink (input valid, search_id, is_search, status, last, output ready);
endinterface

/* rtl/sbs_front.sv */
`timescale 1ns / 1ps

module sbs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  sbs_in_if.sink        in_ch,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output sbs_pkg::cmd_t cmd_o
);

  logic          valid_q, valid_d;
  sbs_pkg::cmd_t cmd_q;
  sbs_pkg::op_e  op_cls;
  logic          accept;

  always_comb begin
    unique case (sbs_pkg::kind_e'(in_ch.kind)) inside
      sbs_pkg::KIND_REGISTER:                         op_cls = sbs_pkg::OP_REG;
      sbs_pkg::KIND_UNREGISTER, sbs_pkg::KIND_ANSWER: op_cls = sbs_pkg::OP_REMOVE;
      sbs_pkg::KIND_NEW_SERVER:                       op_cls = sbs_pkg::OP_BOOST;
      sbs_pkg::KIND_TICK:                             op_cls = sbs_pkg::OP_TICK;
      default:                                        op_cls = sbs_pkg::OP_NOP;
    endcase
  end

  assign in_ch.ready = !valid_q || cmd_ready_i;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.op       <= op_cls;
      cmd_q.id       <= in_ch.channel_id;
      cmd_q.penalize <= in_ch.penalize;
      cmd_q.now      <= in_ch.now_ms;
    end
  end

  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

endmodule

/* rtl/sbs_cmd_fifo.sv */
`timescale 1ns / 1ps

module sbs_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  sbs_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output sbs_pkg::cmd_t pop_cmd_o
);

  sbs_pkg::cmd_t                      mem_q [sbs_pkg::FIFO_DEPTH];
  logic [sbs_pkg::FIFO_PTR_W-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [sbs_pkg::FIFO_CNT_W-1:0]     cnt_q, cnt_d;
  logic                               push, pop;

  assign push_ready_o = cnt_q != sbs_pkg::FIFO_CNT_W'(sbs_pkg::FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == sbs_pkg::FIFO_PTR_W'(sbs_pkg::FIFO_DEPTH - 1)) ? '0
           : wr_q + sbs_pkg::FIFO_PTR_W'(1);
    end
    if (pop) begin
      rd_d = (rd_q == sbs_pkg::FIFO_PTR_W'(sbs_pkg::FIFO_DEPTH - 1)) ? '0
           : rd_q + sbs_pkg::FIFO_PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + sbs_pkg::FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - sbs_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/sbs_back.sv */
`timescale 1ns / 1ps

module sbs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sbs_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  sbs_pkg::cmd_t cmd_i,
  sbs_out_if.source     out_ch,
  output logic          busy_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_COMMIT = 6'b000100,
    S_CHECK  = 6'b001000,
    S_PASS   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  sbs_pkg::cmd_t                   cmd_q, cmd_d;
  sbs_pkg::status_e                status_q, status_d;
  logic [sbs_pkg::IDX_W-1:0]       idx_q, idx_d, match_q, match_d, free_q, free_d;
  logic                            found_q, found_d, free_found_q, free_found_d;
  logic [sbs_pkg::USED_W-1:0]      used_q, used_d, used_after;
  logic                            pass_go_q, pass_go_d;
  logic [sbs_pkg::SRCH_W-1:0]      nsrch_q, nsrch_d;
  logic [sbs_pkg::TIME_W-1:0]      last_pass_q, last_pass_d, delta;
  logic [sbs_pkg::ENTRIES-1:0]     valid_q, valid_d;

  logic [sbs_pkg::ID_W-1:0]        id_mem [sbs_pkg::ENTRIES];
  logic [sbs_pkg::COUNT_W-1:0]     cnt_mem [sbs_pkg::ENTRIES];
  logic [sbs_pkg::ID_W-1:0]        id_rd_q;
  logic [sbs_pkg::COUNT_W-1:0]     cnt_rd_q;

  logic                            out_valid_q, out_valid_d;
  logic [sbs_pkg::ID_W-1:0]        out_id_q, out_id_d;
  logic                            out_srch_q, out_srch_d;
  sbs_pkg::status_e                out_status_q, out_status_d;
  logic                            out_last_q, out_last_d;
  logic                            out_load, out_free;

  logic                            id_we, cnt_we;
  logic [sbs_pkg::IDX_W-1:0]       wr_addr, slot;
  logic [sbs_pkg::ID_W-1:0]        id_wdata;
  logic [sbs_pkg::COUNT_W-1:0]     cnt_wdata, c_in, c_next;
  logic                            cur_valid, at_last, want_emit, stall, go;

  assign cur_valid  = valid_q[idx_q];
  assign at_last    = idx_q == sbs_pkg::IDX_W'(sbs_pkg::ENTRIES - 1);
  assign out_free   = !out_valid_q || out_ch.ready;
  assign slot       = found_q ? match_q : free_q;
  assign used_after = used_q + sbs_pkg::USED_W'(!found_q);
  assign delta      = cmd_q.now - last_pass_q;
  assign go         = cfg_i.enabled && (delta >= sbs_pkg::TIME_W'(cfg_i.guard_ms));
  assign c_in       = (cmd_q.op == sbs_pkg::OP_BOOST) ? cfg_i.boost_count : cnt_rd_q;
  assign want_emit  = pass_go_q && cur_valid && sbs_pkg::pow2(c_in)
                    && (nsrch_q < sbs_pkg::SRCH_W'(sbs_pkg::MAX_SEARCHES));
  assign stall      = want_emit && !out_free;

  always_comb begin
    c_next = c_in;
    if (pass_go_q) begin
      c_next = (c_in >= cfg_i.count_cap) ? cfg_i.fallback_count
             : c_in + sbs_pkg::COUNT_W'(1);
    end
  end

  assign cmd_ready_o = state_q == S_IDLE;
  assign busy_o      = state_q != S_IDLE;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    status_d     = status_q;
    idx_d        = idx_q;
    match_d      = match_q;
    free_d       = free_q;
    found_d      = found_q;
    free_found_d = free_found_q;
    used_d       = used_q;
    pass_go_d    = pass_go_q;
    nsrch_d      = nsrch_q;
    last_pass_d  = last_pass_q;
    valid_d      = valid_q;
    id_we        = 1'b0;
    cnt_we       = 1'b0;
    wr_addr      = idx_q;
    id_wdata     = cmd_q.id;
    cnt_wdata    = c_next;
    out_load     = 1'b0;
    out_id_d     = '0;
    out_srch_d   = 1'b0;
    out_status_d = sbs_pkg::ST_OK;
    out_last_d   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d        = cmd_i;
          status_d     = sbs_pkg::ST_OK;
          idx_d        = '0;
          found_d      = 1'b0;
          free_found_d = 1'b0;
          used_d       = '0;
          unique case (cmd_i.op) inside
            sbs_pkg::OP_REG:                   state_d = cfg_i.enabled ? S_SCAN : S_DONE;
            sbs_pkg::OP_REMOVE:                state_d = S_SCAN;
            sbs_pkg::OP_BOOST, sbs_pkg::OP_TICK: state_d = S_CHECK;
            default:                           state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (cur_valid) begin
          used_d = used_q + sbs_pkg::USED_W'(1);
          if (!found_q && id_rd_q == cmd_q.id) begin
            found_d = 1'b1;
            match_d = idx_q;
          end
        end else if (!free_found_q) begin
          free_found_d = 1'b1;
          free_d       = idx_q;
        end
        if (at_last) begin
          state_d = S_COMMIT;
        end else begin
          idx_d = idx_q + sbs_pkg::IDX_W'(1);
        end
      end
      S_COMMIT: begin
        if (cmd_q.op == sbs_pkg::OP_REG) begin
          if (!found_q && !free_found_q) begin
            status_d = sbs_pkg::ST_FULL;
            state_d  = S_DONE;
          end else begin
            wr_addr       = slot;
            id_we         = 1'b1;
            cnt_we        = 1'b1;
            cnt_wdata     = cmd_q.penalize ? cfg_i.fallback_count : cfg_i.initial_count;
            valid_d[slot] = 1'b1;
            state_d       = (used_after == sbs_pkg::USED_W'(1)) ? S_CHECK : S_DONE;
          end
        end else begin
          if (found_q) begin
            valid_d[match_q] = 1'b0;
          end else begin
            status_d = sbs_pkg::ST_ABSENT;
          end
          state_d = S_DONE;
        end
      end
      S_CHECK: begin
        pass_go_d = go;
        idx_d     = '0;
        nsrch_d   = '0;
        if (go) begin
          last_pass_d = cmd_q.now;
        end
        state_d = (go || cmd_q.op == sbs_pkg::OP_BOOST) ? S_PASS : S_DONE;
      end
      S_PASS: begin
        if (!stall) begin
          cnt_we = cur_valid;
          if (want_emit) begin
            out_load   = 1'b1;
            out_id_d   = id_rd_q;
            out_srch_d = 1'b1;
            nsrch_d    = nsrch_q + sbs_pkg::SRCH_W'(1);
          end
          if (at_last) begin
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + sbs_pkg::IDX_W'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      last_pass_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      last_pass_q <= last_pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    status_q     <= status_d;
    idx_q        <= idx_d;
    match_q      <= match_d;
    free_q       <= free_d;
    found_q      <= found_d;
    free_found_q <= free_found_d;
    used_q       <= used_d;
    pass_go_q    <= pass_go_d;
    nsrch_q      <= nsrch_d;
    if (out_load) begin
      out_id_q     <= out_id_d;
      out_srch_q   <= out_srch_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (id_we) begin
      id_mem[wr_addr] <= id_wdata;
    end
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    id_rd_q  <= id_mem[idx_d];
    cnt_rd_q <= cnt_mem[idx_d];
  end

  assign out_ch.valid     = out_valid_q;
  assign out_ch.search_id = out_id_q;
  assign out_ch.is_search = out_srch_q;
  assign out_ch.status    = out_status_q;
  assign out_ch.last      = out_last_q;

endmodule

/* rtl/search_backoff_scheduler_core.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// in_ch     in         in_ch.valid/ready        kind, channel_id, penalize, now_ms
// out_ch    out        out_ch.valid/ready       search_id, is_search, status, last
// cfg       in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// Back end states per transaction, after the front stage and command queue: new server
// or a tick that runs a pass goes CHECK, PASS, DONE, a tick inside the guard CHECK,
// DONE; unregister, answer or register SCAN, COMMIT, DONE, and a register that checks
// the guard adds CHECK, and PASS when it runs; a disabled register and other kinds DONE.
// Reset clears the slot valid bits and last pass time and loads the configuration defaults at once.
// A busy result port holds the walk on the slot that has a search to emit.

module search_backoff_scheduler_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sbs_in_if.sink                           in_ch,
  sbs_out_if.source                        out_ch,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sbs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  sbs_pkg::cfg_t cfg_q;
  sbs_pkg::cmd_t push_cmd, pop_cmd;
  logic          push_valid, push_ready, pop_valid, pop_ready, busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled        <= 1'b1;
      cfg_q.guard_ms       <= sbs_pkg::GUARD_RST;
      cfg_q.count_cap      <= sbs_pkg::CAP_RST;
      cfg_q.fallback_count <= sbs_pkg::FALLBACK_RST;
      cfg_q.boost_count    <= sbs_pkg::BOOST_RST;
      cfg_q.initial_count  <= sbs_pkg::INITIAL_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sbs_pkg::CFG_ENABLED:  cfg_q.enabled        <= cfg_data_i[0];
        sbs_pkg::CFG_GUARD:    cfg_q.guard_ms       <= cfg_data_i[sbs_pkg::GUARD_W-1:0];
        sbs_pkg::CFG_CAP:      cfg_q.count_cap      <= cfg_data_i[sbs_pkg::COUNT_W-1:0];
        sbs_pkg::CFG_FALLBACK: cfg_q.fallback_count <= cfg_data_i[sbs_pkg::COUNT_W-1:0];
        sbs_pkg::CFG_BOOST:    cfg_q.boost_count    <= cfg_data_i[sbs_pkg::COUNT_W-1:0];
        sbs_pkg::CFG_INITIAL:  cfg_q.initial_count  <= cfg_data_i[sbs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  sbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cmd_valid_o (push_valid),
    .cmd_ready_i (push_ready),
    .cmd_o       (push_cmd)
  );

  sbs_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  sbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_ch      (out_ch),
    .busy_o      (busy)
  );

  a_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready |=> busy)
    else $error("back end idle after taking a command");

  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> push_valid)
    else $error("accepted transaction not held in front stage");

  a_idle_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy && out_ch.valid |-> !out_ch.is_search && out_ch.last)
    else $error("search result pending while back end idle");

endmodule
